// ----- rtl/prrr_pkg.sv -----
// shared types and constants for the page reference-count block
// depends on nothing; used by prrr_walker and page_refcount_run_release
package prrr_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 32;
    localparam int INDEX_W = 3;

    // longest span handled, longer spans are clipped to this
    localparam logic [LEN_W-1:0] MAX_SPAN = 7'd64;

    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    localparam logic [1:0] HEAP_BASE   = 2'd0;
    localparam logic [1:0] HEAP_SYSTEM = 2'd1;
    localparam logic [1:0] HEAP_APP    = 2'd2;

    localparam logic [INDEX_W-1:0] REG_REGION_START     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_BASE_HEAP_LOW    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BASE_HEAP_HIGH   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SYSTEM_HEAP_LOW  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SYSTEM_HEAP_HIGH = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] base_heap_low;
        logic [ADDR_W-1:0] base_heap_high;
        logic [ADDR_W-1:0] system_heap_low;
        logic [ADDR_W-1:0] system_heap_high;
    } cfg_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] span_addr;
        logic [LEN_W-1:0]  span_pages;
        logic              kernel_op;
    } item_t;

    typedef struct packed {
        logic              free_valid;
        logic [ADDR_W-1:0] free_addr;
        logic [LEN_W-1:0]  free_len;
        logic [1:0]        heap_select;
        logic              range_error;
        logic [ADDR_W-1:0] usage_bytes;
        logic              last;
    } result_t;

endpackage

// ----- rtl/prrr_count_ram.sv -----
// page count memory: one write port, one read port, registered read data
// depends on nothing
module prrr_count_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/prrr_walker.sv -----
// span sequencer: clears the count memory, walks each span page by page
// with a read-modify-write pipeline, gathers freed runs into results
// depends on prrr_pkg and prrr_count_ram
module prrr_walker #(
    parameter int TABLE_PAGES = 4096,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prrr_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  prrr_pkg::item_t   in_item,
    output logic              push_valid,
    output prrr_pkg::result_t push_res,
    input  logic              push_ready
);

    localparam int IDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int SW    = prrr_pkg::ADDR_W - PAGE_SHIFT;
    localparam int PG_W  = SW + 1;
    localparam int LW    = prrr_pkg::LEN_W;
    localparam int AW    = prrr_pkg::ADDR_W;
    localparam int CW    = prrr_pkg::COUNT_W;
    localparam logic [PG_W-1:0]  TABLE_LIMIT = PG_W'(TABLE_PAGES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_PAGES - 1);
    localparam logic [CW-1:0]    COUNT_MAX   = {CW{1'b1}};

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SETUP  = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    function automatic logic [1:0] heap_of(input logic [AW-1:0] a, input prrr_pkg::cfg_t c);
        logic [1:0] h;
        if (a >= c.base_heap_low && a < c.base_heap_high)
        begin
            h = prrr_pkg::HEAP_BASE;
        end
        else if (a >= c.system_heap_low && a < c.system_heap_high)
        begin
            h = prrr_pkg::HEAP_SYSTEM;
        end
        else
        begin
            h = prrr_pkg::HEAP_APP;
        end
        return h;
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              op_reg, op_next;
    logic              kern_reg, kern_next;
    logic [AW-1:0]     diff_reg, diff_next;
    logic [LW-1:0]     n_reg, n_next;
    logic              err_reg, err_next;
    logic [PG_W-1:0]   iss_p_reg, iss_p_next;
    logic [LW-1:0]     iss_left_reg, iss_left_next;
    logic              mod_v_reg, mod_v_next;
    logic [PG_W-1:0]   mod_p_reg, mod_p_next;
    logic              mod_in_reg, mod_in_next;
    logic [LW-1:0]     run_len_reg, run_len_next;
    logic [AW-1:0]     run_addr_reg, run_addr_next;
    logic              pend_v_reg, pend_v_next;
    prrr_pkg::result_t pend_reg, pend_next;
    logic [AW-1:0]     usage_reg, usage_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic              ram_re;
    logic [CW-1:0]     ram_rdata;

    logic [PG_W-1:0]   start_ext;
    logic              iss_in;
    logic [CW-1:0]     cnt_new;
    logic              freed;
    logic              rel_run;
    logic              fin_push;
    logic              stall;
    logic [AW-1:0]     usage_after;
    prrr_pkg::result_t new_res;
    prrr_pkg::result_t null_res;

    prrr_count_ram #(
        .DEPTH (TABLE_PAGES),
        .AW    (IDX_W),
        .DW    (CW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (iss_p_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign start_ext = PG_W'(diff_reg >> PAGE_SHIFT);
    assign iss_in    = (iss_p_reg < TABLE_LIMIT);

    always_comb
    begin
        if (op_reg == prrr_pkg::OP_OPEN)
        begin
            cnt_new = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
        end
        else
        begin
            cnt_new = ram_rdata - 1'b1;
        end
    end

    assign freed = (state_reg == ST_RUN) && mod_v_reg && mod_in_reg &&
                   (op_reg == prrr_pkg::OP_CLOSE) && (cnt_new == '0);

    assign rel_run = ((state_reg == ST_RUN) && mod_v_reg && (op_reg == prrr_pkg::OP_CLOSE) &&
                      !freed && (run_len_reg != '0)) ||
                     ((state_reg == ST_FINISH) && (run_len_reg != '0));

    assign fin_push = (state_reg == ST_FINISH) && (run_len_reg == '0);

    assign usage_after = kern_reg ? usage_reg - (AW'(run_len_reg) << PAGE_SHIFT) : usage_reg;

    always_comb
    begin
        new_res             = '0;
        new_res.free_valid  = 1'b1;
        new_res.free_addr   = run_addr_reg;
        new_res.free_len    = run_len_reg;
        new_res.heap_select = heap_of(run_addr_reg, cfg);
        new_res.range_error = err_reg;
        new_res.usage_bytes = usage_after;
        new_res.last        = 1'b0;

        null_res             = '0;
        null_res.range_error = err_reg;
        null_res.usage_bytes = usage_reg;
        null_res.last        = 1'b1;
    end

    // a finished run goes out only once the next one, or the end, is known
    always_comb
    begin
        push_valid = (rel_run && pend_v_reg) || fin_push;
        push_res   = pend_reg;
        if (fin_push)
        begin
            push_res      = pend_v_reg ? pend_reg : null_res;
            push_res.last = 1'b1;
        end
    end

    assign stall    = push_valid && !push_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = mod_p_reg[IDX_W-1:0];
        ram_wdata = cnt_new;
        ram_re    = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_RUN && !stall)
        begin
            ram_we = mod_v_reg && mod_in_reg;
            ram_re = (iss_left_reg != '0) && iss_in;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        op_next       = op_reg;
        kern_next     = kern_reg;
        diff_next     = diff_reg;
        n_next        = n_reg;
        err_next      = err_reg;
        iss_p_next    = iss_p_reg;
        iss_left_next = iss_left_reg;
        mod_v_next    = mod_v_reg;
        mod_p_next    = mod_p_reg;
        mod_in_next   = mod_in_reg;
        run_len_next  = run_len_reg;
        run_addr_next = run_addr_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        usage_next    = usage_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item.opcode;
                    kern_next  = in_item.kernel_op;
                    diff_next  = in_item.span_addr - cfg.region_start;
                    n_next     = (in_item.span_pages > prrr_pkg::MAX_SPAN) ?
                                 prrr_pkg::MAX_SPAN : in_item.span_pages;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                iss_p_next    = start_ext;
                iss_left_next = n_reg;
                err_next      = (n_reg != '0) && ((start_ext + PG_W'(n_reg)) > TABLE_LIMIT);
                mod_v_next    = 1'b0;
                run_len_next  = '0;
                pend_v_next   = 1'b0;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    if (iss_left_reg != '0)
                    begin
                        mod_v_next    = 1'b1;
                        mod_p_next    = iss_p_reg;
                        mod_in_next   = iss_in;
                        iss_p_next    = iss_p_reg + 1'b1;
                        iss_left_next = iss_left_reg - 1'b1;
                    end
                    else
                    begin
                        mod_v_next = 1'b0;
                        if (!mod_v_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    if (freed)
                    begin
                        if (run_len_reg == '0)
                        begin
                            run_addr_next = cfg.region_start +
                                            (AW'(mod_p_reg[IDX_W-1:0]) << PAGE_SHIFT);
                        end
                        run_len_next = run_len_reg + 1'b1;
                    end
                    if (rel_run)
                    begin
                        pend_v_next  = 1'b1;
                        pend_next    = new_res;
                        usage_next   = usage_after;
                        run_len_next = '0;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!stall)
                begin
                    if (rel_run)
                    begin
                        pend_v_next  = 1'b1;
                        pend_next    = new_res;
                        usage_next   = usage_after;
                        run_len_next = '0;
                    end
                    else
                    begin
                        pend_v_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            iss_left_reg <= '0;
            mod_v_reg    <= 1'b0;
            run_len_reg  <= '0;
            pend_v_reg   <= 1'b0;
            usage_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            iss_left_reg <= iss_left_next;
            mod_v_reg    <= mod_v_next;
            run_len_reg  <= run_len_next;
            pend_v_reg   <= pend_v_next;
            usage_reg    <= usage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        kern_reg     <= kern_next;
        diff_reg     <= diff_next;
        n_reg        <= n_next;
        err_reg      <= err_next;
        iss_p_reg    <= iss_p_next;
        mod_p_reg    <= mod_p_next;
        mod_in_reg   <= mod_in_next;
        run_addr_reg <= run_addr_next;
        pend_reg     <= pend_next;
    end

endmodule

// ----- rtl/page_refcount_run_release.sv -----
// page reference-count table with run release; top level
// spans are clipped to 64 pages; one item at a time: the next span is accepted only after
// the last word of the current one has been pushed; the read-modify-write pass handles one
// page a cycle unless the output stalls
// reset: usage total and registers clear; a clearing pass then zeroes every entry
// of the count memory with s_tready low (config writes still taken)
// depends on prrr_pkg and prrr_walker
module page_refcount_run_release #(
    parameter int TABLE_PAGES = 4096,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // span_addr[31:0], span_pages[38:32], zero pad
    input  logic [1:0]  s_tuser,   // opcode[0], kernel_op[1]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // free_addr[31:0], free_len[38:32], range_error[39],
                                   // usage_bytes[71:40]
    output logic [2:0]  m_tuser,   // free_valid[0], heap_select[2:1]
    output logic        m_tlast,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    prrr_pkg::cfg_t    cfg_reg, cfg_next;
    prrr_pkg::item_t   item;
    prrr_pkg::result_t push_res;
    prrr_pkg::result_t out_reg;
    logic              out_v_reg, out_v_next;
    logic              push_valid;
    logic              push_ready;

    // config registers, unknown indexes fall through
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                prrr_pkg::REG_REGION_START:     cfg_next.region_start     = cfg_data;
                prrr_pkg::REG_BASE_HEAP_LOW:    cfg_next.base_heap_low    = cfg_data;
                prrr_pkg::REG_BASE_HEAP_HIGH:   cfg_next.base_heap_high   = cfg_data;
                prrr_pkg::REG_SYSTEM_HEAP_LOW:  cfg_next.system_heap_low  = cfg_data;
                prrr_pkg::REG_SYSTEM_HEAP_HIGH: cfg_next.system_heap_high = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the input word
    always_comb
    begin
        item.opcode     = s_tuser[0];
        item.kernel_op  = s_tuser[1];
        item.span_addr  = s_tdata[31:0];
        item.span_pages = s_tdata[38:32];
    end

    prrr_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .push_valid (push_valid),
        .push_res   (push_res),
        .push_ready (push_ready)
    );

    // output register: a new word may load in the cycle the old one leaves
    assign push_ready = !out_v_reg || m_tready;

    always_comb
    begin
        out_v_next = out_v_reg;
        if (push_valid && push_ready)
        begin
            out_v_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            out_reg <= push_res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.heap_select, out_reg.free_valid};
    assign m_tdata  = {out_reg.usage_bytes, out_reg.range_error, out_reg.free_len,
                       out_reg.free_addr};

endmodule

// ----- sim/page_refcount_run_release_test.sv -----
// self-checking testbench for the page reference-count table with run release
// drives span words into page_refcount_run_release and checks every released-run word
// against an in-bench model of the counts; needs prrr_pkg and the rtl under rtl/
module page_refcount_run_release_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W       = prrr_pkg::ADDR_W;
    localparam int LEN_W        = prrr_pkg::LEN_W;
    localparam int COUNT_W      = prrr_pkg::COUNT_W;
    localparam int CFG_W        = prrr_pkg::CFG_W;
    localparam int INDEX_W      = prrr_pkg::INDEX_W;
    localparam int TABLE_PAGES  = 4096;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    // sized from the longest span so that it covers the slowest one
    localparam int DRAIN_CYCLES = int'(prrr_pkg::MAX_SPAN) + 16;
    localparam int LIMIT_CYCLES = 1_000_000;
    // pages used by the random traffic, counted from region_start
    localparam int WINDOW_PAGES = 96;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // span_addr[31:0], span_pages[38:32], zero pad
    logic [1:0]  s_tuser;    // opcode[0], kernel_op[1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;    // free_addr[31:0], free_len[38:32], range_error[39],
                             // usage_bytes[71:40]
    logic [2:0]  m_tuser;    // free_valid[0], heap_select[2:1]
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // model of the block: counts, usage total and the register file
    logic [COUNT_W-1:0] page_refs [TABLE_PAGES];
    logic [ADDR_W-1:0]  kernel_total;
    prrr_pkg::cfg_t     layout;

    // words the block owes us, oldest first
    prrr_pkg::result_t release_words [$];

    // spans opened by the random traffic, kept so that later closes can match them
    int live_page [$];
    int live_len  [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int errors         = 0;
    int cycle_count    = 0;

    page_refcount_run_release #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs or drops a word
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t timeout after %0d cycles, %0d words outstanding", $time,
                     cycle_count, release_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------

    // base wins over system where the two windows overlap
    function automatic logic [1:0] heap_for(logic [ADDR_W-1:0] addr);
        if (addr >= layout.base_heap_low && addr < layout.base_heap_high)
            return prrr_pkg::HEAP_BASE;
        if (addr >= layout.system_heap_low && addr < layout.system_heap_high)
            return prrr_pkg::HEAP_SYSTEM;
        return prrr_pkg::HEAP_APP;
    endfunction

    // one released run; a kernel close takes its bytes off the usage total first
    function automatic prrr_pkg::result_t run_word(int unsigned first, int unsigned len,
                                                   logic kern, logic err);
        prrr_pkg::result_t w;
        logic [ADDR_W-1:0] bytes;
        w = '0;
        bytes = ADDR_W'(len) << PAGE_SHIFT;
        if (kern)
            kernel_total = kernel_total - bytes;
        w.free_valid  = 1'b1;
        w.free_addr   = layout.region_start + (ADDR_W'(first) << PAGE_SHIFT);
        w.free_len    = LEN_W'(len);
        w.heap_select = heap_for(w.free_addr);
        w.range_error = err;
        w.usage_bytes = kernel_total;
        return w;
    endfunction

    // updates the counts for one accepted span and queues the words it owes
    function automatic void apply_span(prrr_pkg::item_t it);
        logic [ADDR_W-1:0] offset;
        int unsigned first, pages, p, run_first, run_len;
        logic err, freed;
        prrr_pkg::result_t w;
        prrr_pkg::result_t batch [$];
        offset = it.span_addr - layout.region_start;
        first = offset >> PAGE_SHIFT;
        pages = (it.span_pages > prrr_pkg::MAX_SPAN) ? int'(prrr_pkg::MAX_SPAN) :
                                                      int'(it.span_pages);
        run_first = 0;
        run_len = 0;
        err = 1'b0;
        // the error flag goes on every word of the span, so find it up front
        for (int i = 0; i < pages; i++)
            if (first + i >= TABLE_PAGES)
                err = 1'b1;
        for (int i = 0; i < pages; i++)
        begin
            p = first + i;
            freed = 1'b0;
            if (p < TABLE_PAGES)
            begin
                if (it.opcode == prrr_pkg::OP_OPEN)
                begin
                    if (page_refs[p] != '1)
                        page_refs[p] = page_refs[p] + 1'b1;
                end
                else
                begin
                    // decrement from zero wraps to all ones and is not a release
                    page_refs[p] = page_refs[p] - 1'b1;
                    freed = (page_refs[p] == '0);
                end
            end
            if (it.opcode == prrr_pkg::OP_CLOSE)
            begin
                if (freed)
                begin
                    if (run_len == 0)
                        run_first = p;
                    run_len++;
                end
                else if (run_len != 0)
                begin
                    // a held page or an out-of-table page breaks the run
                    batch.push_back(run_word(run_first, run_len, it.kernel_op, err));
                    run_len = 0;
                end
            end
        end
        if (run_len != 0)
            batch.push_back(run_word(run_first, run_len, it.kernel_op, err));
        if (batch.size() == 0)
        begin
            // nothing released: a single empty word still carries the status
            w = '0;
            w.range_error = err;
            w.usage_bytes = kernel_total;
            batch.push_back(w);
        end
        w = batch.pop_back();
        w.last = 1'b1;
        batch.push_back(w);
        foreach (batch[i])
            release_words.push_back(batch[i]);
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stalls, or a solid hold-off while hold_left runs down
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            errors++;
            $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        prrr_pkg::result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.free_addr   = m_tdata[31:0];
            got.free_len    = m_tdata[38:32];
            got.range_error = m_tdata[39];
            got.usage_bytes = m_tdata[71:40];
            got.free_valid  = m_tuser[0];
            got.heap_select = m_tuser[2:1];
            got.last        = m_tlast;
            if (release_words.size() == 0)
            begin
                errors++;
                $display("%0t unexpected word: expected none, actual addr %h len %0d last %b",
                         $time, got.free_addr, got.free_len, got.last);
            end
            else
            begin
                want = release_words.pop_front();
                check_field("free_valid", want.free_valid, got.free_valid);
                check_field("free_addr", want.free_addr, got.free_addr);
                check_field("free_len", want.free_len, got.free_len);
                check_field("heap_select", want.heap_select, got.heap_select);
                check_field("range_error", want.range_error, got.range_error);
                check_field("usage_bytes", want.usage_bytes, got.usage_bytes);
                check_field("last", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic prrr_pkg::item_t make_item(logic op, logic [ADDR_W-1:0] addr,
                                                  int pages, logic kern);
        prrr_pkg::item_t it;
        it.opcode     = op;
        it.span_addr  = addr;
        it.span_pages = LEN_W'(pages);
        it.kernel_op  = kern;
        return it;
    endfunction

    // byte address of a table page under the current region base
    function automatic logic [ADDR_W-1:0] page_addr(int page);
        return layout.region_start + (ADDR_W'(page) << PAGE_SHIFT);
    endfunction

    // offers one word, idling first at the sender's rate, and returns once it is taken
    task automatic send_item(input prrr_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.span_pages, it.span_addr};
        s_tuser  <= {it.kernel_op, it.opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_span(it);
    endtask

    // register writes only happen with the block idle, see settle
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            prrr_pkg::REG_REGION_START:     layout.region_start     = value;
            prrr_pkg::REG_BASE_HEAP_LOW:    layout.base_heap_low    = value;
            prrr_pkg::REG_BASE_HEAP_HIGH:   layout.base_heap_high   = value;
            prrr_pkg::REG_SYSTEM_HEAP_LOW:  layout.system_heap_low  = value;
            prrr_pkg::REG_SYSTEM_HEAP_HIGH: layout.system_heap_high = value;
            default: ;
        endcase
    endtask

    // stop offering, let every owed word out, then give the pipeline time to go quiet
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (release_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // random region and heap windows, mostly around the traffic window
    task automatic pick_random_layout();
        logic [ADDR_W-1:0] region, low;
        case ($urandom_range(3))
            0: region = '0;
            1: region = $urandom & ~ADDR_W'(PAGE_BYTES - 1);
            // close to the top so run addresses wrap past zero
            2: region = 32'hFFFF_FFFF - (ADDR_W'($urandom_range(0, 32)) << PAGE_SHIFT);
            default: region = $urandom;
        endcase
        write_reg(prrr_pkg::REG_REGION_START, region);
        low = region + (ADDR_W'($urandom_range(0, 32)) << PAGE_SHIFT);
        write_reg(prrr_pkg::REG_BASE_HEAP_LOW, low);
        write_reg(prrr_pkg::REG_BASE_HEAP_HIGH,
                  low + (ADDR_W'($urandom_range(0, 48)) << PAGE_SHIFT));
        low = region + (ADDR_W'($urandom_range(0, 96)) << PAGE_SHIFT);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_LOW, low);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH,
                  low + (ADDR_W'($urandom_range(0, 64)) << PAGE_SHIFT));
        // sometimes a window that is inverted or spans the whole map
        if ($urandom_range(3) == 0)
            write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH, $urandom);
        // spare indexes must leave the register file alone
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH + INDEX_W'($urandom_range(1, 3)), $urandom);
    endtask

    // mostly open/close pairs on the traffic window, some raw noise words
    function automatic prrr_pkg::item_t draw_span();
        prrr_pkg::item_t it;
        int roll, page, len, pick;
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            it.opcode     = 1'($urandom_range(1));
            it.span_addr  = $urandom;
            it.span_pages = LEN_W'($urandom_range(127));
            it.kernel_op  = 1'($urandom_range(1));
            return it;
        end
        if (roll < 62 || live_page.size() == 0)
        begin
            // fresh open, now and then running off the end of the table
            if ($urandom_range(9) == 0)
                page = TABLE_PAGES - $urandom_range(1, 24);
            else
                page = $urandom_range(WINDOW_PAGES - 1);
            if ($urandom_range(9) == 0)
                len = $urandom_range(1, 127);
            else
                len = $urandom_range(1, 12);
            live_page.push_back(page);
            live_len.push_back(len);
            it.opcode = prrr_pkg::OP_OPEN;
        end
        else
        begin
            pick = $urandom_range(live_page.size() - 1);
            page = live_page[pick];
            len  = live_len[pick];
            live_page.delete(pick);
            live_len.delete(pick);
            // an odd length now and then, zero included
            if ($urandom_range(6) == 0)
                len = $urandom_range(127);
            it.opcode = prrr_pkg::OP_CLOSE;
        end
        it.span_addr  = page_addr(page) + ADDR_W'($urandom_range(PAGE_BYTES - 1));
        it.span_pages = LEN_W'(len);
        it.kernel_op  = 1'($urandom_range(1));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at reset: region at zero, both heap windows empty
    task automatic test_reset_defaults();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // zero-length spans give one empty word
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(0), 0, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(0), 0, 1'b1));
        // kernel open and kernel close of three pages, usage wraps below zero
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(0), 3, 1'b1));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(0), 3, 1'b1));
        // close of an unused page wraps its count and frees nothing
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(10), 1, 1'b0));
        // the wrapped count is all ones, so this open saturates
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(10), 1, 1'b0));
        // oversized span is clipped to the longest span
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(100), 127, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(100), int'(prrr_pkg::MAX_SPAN),
                            1'b1));
        settle();
    endtask

    task automatic test_range_errors();
        // straddles the table end: error flag on the open and on the released run
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(TABLE_PAGES - 6), 10, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(TABLE_PAGES - 6), 10, 1'b1));
        // wholly outside the table
        send_item(make_item(prrr_pkg::OP_CLOSE, 32'hFFFF_F000, 5, 1'b0));
        settle();
    endtask

    // a page still referenced splits the close into two runs; unaligned addresses
    task automatic test_fragmented_release();
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(200) + 32'h0ABC, 3, 1'b0));
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(201) + 32'h0FFF, 1, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(200) + 32'h0001, 3, 1'b1));
        settle();
    endtask

    // region two pages below the top of the map: the second run starts at zero
    task automatic test_address_wrap();
        write_reg(prrr_pkg::REG_REGION_START, 32'hFFFF_E000);
        write_reg(prrr_pkg::REG_BASE_HEAP_LOW, '0);
        write_reg(prrr_pkg::REG_BASE_HEAP_HIGH, '0);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_LOW, '0);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH, '0);
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(0), 4, 1'b0));
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(1), 1, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(0), 4, 1'b1));
        settle();
    endtask

    task automatic test_heap_select();
        write_reg(prrr_pkg::REG_REGION_START, 32'h0010_0000);
        write_reg(prrr_pkg::REG_BASE_HEAP_LOW, page_addr(300));
        write_reg(prrr_pkg::REG_BASE_HEAP_HIGH, page_addr(316));
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_LOW, page_addr(316));
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH, page_addr(332));
        // held pages at 310, 320 and 340 cut the close into base, base, system, app runs
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(300), 64, 1'b0));
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(310), 1, 1'b0));
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(320), 1, 1'b0));
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(340), 1, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(300), 64, 1'b1));
        settle();
        // extremes: region at the very top, base covers all but the top address
        write_reg(prrr_pkg::REG_REGION_START, 32'hFFFF_FFFF);
        write_reg(prrr_pkg::REG_BASE_HEAP_LOW, '0);
        write_reg(prrr_pkg::REG_BASE_HEAP_HIGH, 32'hFFFF_FFFF);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_LOW, 32'hFFFF_FFFF);
        write_reg(prrr_pkg::REG_SYSTEM_HEAP_HIGH, 32'hFFFF_FFFF);
        // run at the top address lands in the application heap
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(0), 2, 1'b0));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(0), 2, 1'b0));
        // one page on it has wrapped into the base window
        send_item(make_item(prrr_pkg::OP_OPEN, page_addr(1), 1, 1'b1));
        send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(1), 1, 1'b1));
        settle();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        pick_random_layout();
        repeat (count)
            send_item(draw_span());
        settle();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the block backs up and drops s_tready
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 400;
        for (int k = 0; k < 8; k++)
            send_item(make_item(prrr_pkg::OP_OPEN, page_addr(500 + 8 * k), 8, 1'b0));
        for (int k = 0; k < 8; k++)
            send_item(make_item(prrr_pkg::OP_CLOSE, page_addr(500 + 8 * k), 8, 1'(k)));
        settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (page_refs[i])
            page_refs[i] = '0;
        kernel_total = '0;
        layout = '0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset holds s_tready low; send_item waits it out
        test_reset_defaults();
        test_range_errors();
        test_fragmented_release();
        test_address_wrap();
        test_heap_select();
        test_random_traffic(0, 0, 80);
        test_random_traffic(81, 0, 70);
        test_random_traffic(0, 81, 70);
        test_random_traffic(24, 24, 70);
        test_output_backpressure();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
